// ----- rtl/mcg_pkg.sv -----
`default_nettype none

package mcg_pkg;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // Stop count after reset
    localparam logic [3:0] STOP_COUNT_RST = 4'd2;

    // Q1.16 one, as a 17-bit interpolation weight
    localparam logic [16:0] T_ONE = 17'h1_0000;

    // Channel numbers, red first
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  stop_index;
        logic [15:0] stop_position;
        logic [7:0]  stop_red;
        logic [7:0]  stop_green;
        logic [7:0]  stop_blue;
        logic [7:0]  stop_alpha;
        logic [15:0] sample_position;
    } t_req;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_rsp;

    // Stop color, red in the low byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    typedef struct packed {
        logic [15:0] pos;
        t_color      col;
    } t_stop;

    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } t_div_cmd;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } t_div_sts;

    typedef struct packed {
        logic        valid;
        logic [1:0]  ch;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [16:0] t;
    } t_lerp_cmd;

    typedef struct packed {
        logic       valid;
        logic [1:0] ch;
        logic [7:0] value;
    } t_lerp_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_DIV,
        S_LERP,
        S_WAIT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/mcg_stop_mem.sv -----
`default_nettype none

module mcg_stop_mem #(
    parameter  int DEPTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [AW-1:0]     i_waddr,
    input  mcg_pkg::t_stop   i_wdata,
    input  wire [AW-1:0]     i_raddr,
    output mcg_pkg::t_stop   o_rdata
);
    import mcg_pkg::*;

    t_stop r_mem [DEPTH];
    t_stop r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/mcg_div.sv -----
`default_nettype none

module mcg_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  mcg_pkg::t_div_cmd i_cmd,
    output mcg_pkg::t_div_sts o_sts
);
    import mcg_pkg::*;

    logic        r_run;
    logic        r_done;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] r_quo;
    logic [3:0]  r_cnt;

    logic [16:0] w_shift;
    logic [16:0] w_diff;
    logic        w_ge;
    logic        w_sat;

    // One restoring step per cycle: the remainder stays below the divisor
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};
    // Quotient of one or more saturates to one
    assign w_sat   = (i_cmd.num >= i_cmd.den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run  <= !w_sat;
                r_done <= w_sat;
            end else if (r_run && (r_cnt == 4'd0)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_cmd.num;
            r_den <= i_cmd.den;
            r_cnt <= 4'd15;
            r_quo <= w_sat ? T_ONE : '0;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[15:0] : w_shift[15:0];
            r_quo <= {r_quo[15:0], w_ge};
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_sts = '{done: r_done, quo: r_quo};

endmodule

`default_nettype wire

// ----- rtl/mcg_lerp.sv -----
`default_nettype none

module mcg_lerp (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  mcg_pkg::t_lerp_cmd i_cmd,
    output mcg_pkg::t_lerp_sts o_sts
);
    import mcg_pkg::*;

    logic signed [8:0]  w_diff;
    logic signed [26:0] w_prod;
    logic signed [26:0] w_acc;

    logic       r_valid;
    logic [1:0] r_ch;
    logic [7:0] r_value;

    // L * 2^16 + (R - L) * t + 2^15, then keep bits 23:16
    assign w_diff = $signed({1'b0, i_cmd.right}) - $signed({1'b0, i_cmd.left});
    assign w_prod = 27'(w_diff) * 27'($signed({1'b0, i_cmd.t}));
    assign w_acc  = $signed({3'b000, i_cmd.left, 16'h0000}) + w_prod + 27'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch    <= i_cmd.ch;
        r_value <= w_acc[23:16];
    end

    assign o_sts = '{valid: r_valid, ch: r_ch, value: r_value};

endmodule

`default_nettype wire

// ----- rtl/multi_stop_color_gradient.sv -----
`default_nettype none

// Multi-stop linear color gradient.
// A transaction is taken on a rising edge with start high and busy low; i_req
// carries it. A write transaction (req_type = REQ_WRITE) stores one stop and
// gives no result; busy stays low. An evaluate transaction raises busy until
// its color has been driven on o_rsp with o_done high for exactly one cycle.
// The receiver cannot stall, so the result is never held.
// An evaluation reads the first stop and returns its color when the sample is
// at or below it; else it reads the last stop and returns its color when the
// sample is at or above it; else it scans the stops from index 1 for the first
// one at or above the sample, forms the weight in the 16-step serial divider
// and blends the four channels in turn in the one shared multiplier. The stop
// scan goes through the single read port of the stop table. busy falls in the
// cycle o_done is high, so the next transaction may start then.
// i_cfg_we writes the stop count (values below 2 act as 2, above MAX_STOPS as
// MAX_STOPS). Reset sets the stop count to 2 and idles the sequencer; the
// stop table is not cleared and must be written before it is read.
module multi_stop_color_gradient #(
    parameter int MAX_STOPS = 8
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  mcg_pkg::t_req  i_req,
    output logic           o_done,
    output mcg_pkg::t_rsp  o_rsp,
    input  wire            i_cfg_we,
    input  wire [3:0]      i_cfg_wdata
);
    import mcg_pkg::*;

    localparam int IW      = $clog2(MAX_STOPS);
    localparam int CNT_MAX = (MAX_STOPS < 15) ? MAX_STOPS : 15;

    // Control state
    t_state      r_state, n_state;
    logic [3:0]  r_stop_count;
    logic        r_done, n_done;

    // Working registers
    logic [15:0] r_p, n_p;
    logic [IW-1:0] r_idx, n_idx;
    t_stop       r_left, n_left;
    t_color      r_right_col, n_right_col;
    logic [1:0]  r_ch, n_ch;
    logic [16:0] r_t, n_t;
    logic [23:0] r_rgb, n_rgb;
    t_rsp        r_rsp, n_rsp;

    // Datapath links
    logic          w_accept;
    logic          w_we;
    logic [IW-1:0] w_last;
    logic [IW-1:0] w_raddr;
    t_stop         w_wdata;
    t_stop         w_rd;
    t_div_cmd      w_div_cmd;
    t_div_sts      w_div_sts;
    t_lerp_cmd     w_lerp_cmd;
    t_lerp_sts     w_lerp_sts;
    logic [16:0]   w_num;
    logic [16:0]   w_rng;
    logic [31:0]   w_lcol;
    logic [31:0]   w_rcol;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Drop writes whose index lies beyond the table
    assign w_we = w_accept && (i_req.req_type == REQ_WRITE)
                  && (int'(i_req.stop_index) < MAX_STOPS);

    assign w_wdata = '{
        pos: i_req.stop_position,
        col: '{alpha: i_req.stop_alpha, blue: i_req.stop_blue,
               green: i_req.stop_green, red: i_req.stop_red}
    };

    // Index of the last valid stop
    always_comb begin
        if (r_stop_count < 4'd2) begin
            w_last = IW'(1);
        end else if (int'(r_stop_count) > CNT_MAX) begin
            w_last = IW'(CNT_MAX - 1);
        end else begin
            w_last = IW'(r_stop_count - 4'd1);
        end
    end

    mcg_stop_mem #(
        .DEPTH (MAX_STOPS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IW'(i_req.stop_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    mcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_sts   (w_div_sts)
    );

    mcg_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_lerp_cmd),
        .o_sts   (w_lerp_sts)
    );

    // Distances from the left stop, 17 bits so the sign shows
    assign w_num  = {1'b0, r_p} - {1'b0, r_left.pos};
    assign w_rng  = {1'b0, w_rd.pos} - {1'b0, r_left.pos};
    assign w_lcol = r_left.col;
    assign w_rcol = r_right_col;

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_p         = r_p;
        n_idx       = r_idx;
        n_left      = r_left;
        n_right_col = r_right_col;
        n_ch        = r_ch;
        n_t         = r_t;
        n_rgb       = r_rgb;
        n_rsp       = r_rsp;
        w_raddr     = '0;
        w_div_cmd   = '{start: 1'b0, num: 16'h0000, den: 16'h0001};
        w_lerp_cmd  = '{valid: 1'b0, ch: r_ch,
                        left: w_lcol[{r_ch, 3'b000} +: 8],
                        right: w_rcol[{r_ch, 3'b000} +: 8],
                        t: r_t};

        // Collect the blended red, green and blue channels as they come back
        if (w_lerp_sts.valid && (w_lerp_sts.ch != CH_ALPHA)) begin
            n_rgb[{w_lerp_sts.ch, 3'b000} +: 8] = w_lerp_sts.value;
        end

        case (r_state)
            S_IDLE: begin
                // Read stop 0 ahead of time
                w_raddr = '0;
                if (w_accept && (i_req.req_type == REQ_EVAL)) begin
                    n_p     = i_req.sample_position;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                if (r_p <= w_rd.pos) begin
                    n_rsp   = '{out_red: w_rd.col.red, out_green: w_rd.col.green,
                                out_blue: w_rd.col.blue, out_alpha: w_rd.col.alpha};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_left  = w_rd;
                    w_raddr = w_last;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_p >= w_rd.pos) begin
                    n_rsp   = '{out_red: w_rd.col.red, out_green: w_rd.col.green,
                                out_blue: w_rd.col.blue, out_alpha: w_rd.col.alpha};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = IW'(1);
                    n_idx   = IW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_raddr = r_idx + IW'(1);
                if (r_p <= w_rd.pos) begin
                    // Found the right stop: start the weight division
                    n_right_col     = w_rd.col;
                    w_div_cmd.start = 1'b1;
                    w_div_cmd.num   = (!w_num[16] && (w_num[15:0] != 16'h0000))
                                      ? w_num[15:0] : 16'h0000;
                    w_div_cmd.den   = (!w_rng[16] && (w_rng[15:0] != 16'h0000))
                                      ? w_rng[15:0] : 16'h0001;
                    n_state         = S_DIV;
                end else if (r_idx == w_last) begin
                    // No stop matched: take the last color
                    n_rsp   = '{out_red: w_rd.col.red, out_green: w_rd.col.green,
                                out_blue: w_rd.col.blue, out_alpha: w_rd.col.alpha};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_left = w_rd;
                    n_idx  = r_idx + IW'(1);
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_t     = w_div_sts.quo;
                    n_ch    = CH_RED;
                    n_state = S_LERP;
                end
            end
            S_LERP: begin
                // Issue one channel per cycle to the shared blender
                w_lerp_cmd.valid = 1'b1;
                n_ch             = r_ch + 2'd1;
                if (r_ch == CH_ALPHA) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_lerp_sts.valid) begin
                    n_rsp   = '{out_red: r_rgb[7:0], out_green: r_rgb[15:8],
                                out_blue: r_rgb[23:16], out_alpha: w_lerp_sts.value};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_stop_count <= STOP_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_stop_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_idx       <= n_idx;
        r_left      <= n_left;
        r_right_col <= n_right_col;
        r_ch        <= n_ch;
        r_t         <= n_t;
        r_rgb       <= n_rgb;
        r_rsp       <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire
